FILE: rtl/acmc_pkg.sv
`default_nettype none

package acmc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;

    localparam int GAIN_W     = 18;
    localparam int RATIO_W    = 17;
    localparam int THRESH_W   = 24;
    localparam int KNEE_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int GAIN_FRAC   = 16;
    localparam int RATIO_FRAC  = 16;
    localparam int THRESH_FRAC = 23;
    localparam int KNEE_FRAC   = 24;
    localparam int MIX_FRAC    = 23;

    localparam int STAGES = 6;

    localparam logic [RATIO_W-1:0] UNITY_RATIO = RATIO_W'(64'd1 << RATIO_FRAC);

    // Gained sample: the gain stays below 4.0, so two integer bits are added.
    localparam int G_W = SAMPLE_BITS + 2;

    localparam int THR_SHL = (FRAC_BITS > THRESH_FRAC) ? FRAC_BITS - THRESH_FRAC : 0;
    localparam int THR_SHR = (FRAC_BITS < THRESH_FRAC) ? THRESH_FRAC - FRAC_BITS : 0;
    localparam int THR_W   = THRESH_W + THR_SHL;
    localparam int BASE_W  = (THR_W > FRAC_BITS + 1) ? THR_W : FRAC_BITS + 1;
    localparam int D_W     = ((G_W > BASE_W + 1) ? G_W : BASE_W + 1) + 1;
    localparam int SC_W    = D_W + RATIO_W + 1 - RATIO_FRAC;
    localparam int R_W     = ((SC_W > BASE_W + 1) ? SC_W : BASE_W + 1) + 1;
    localparam int V_W     = FRAC_BITS + 1;
    localparam int AV_W    = KNEE_W + V_W + 1 - KNEE_FRAC;
    localparam int CT_W    = KNEE_W + FRAC_BITS;
    localparam int CTS_W   = CT_W - KNEE_FRAC;
    localparam int Q_W     = AV_W + 2;
    localparam int RR_W    = (Q_W + 1 > R_W) ? Q_W + 1 : R_W;
    localparam int CL_W    = G_W;

    localparam int MIXG_W = 25;
    localparam int MIX_W  = G_W + MIXG_W - MIX_FRAC;
    localparam int SAT_W  = MIX_W + 2;

    localparam logic signed [D_W-1:0] ONE_D = D_W'(64'sd1 <<< FRAC_BITS);

    localparam logic signed [RR_W-1:0] CL_HI = RR_W'((64'sd1 <<< (FRAC_BITS + 2)) - 64'sd1);
    localparam logic signed [RR_W-1:0] CL_LO = -CL_HI - RR_W'(1);

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    localparam logic signed [MIXG_W-1:0] GAIN_S0 = MIXG_W'(1329505);
    localparam logic signed [MIXG_W-1:0] GAIN_S1 = MIXG_W'(4204263);
    localparam logic signed [MIXG_W-1:0] GAIN_L0 = MIXG_W'(14917289);
    localparam logic signed [MIXG_W-1:0] GAIN_L1 = MIXG_W'(11849224);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INPUT_GAIN  = 3'd0,
        CFG_MODE_SELECT = 3'd1,
        CFG_RATIO       = 3'd2,
        CFG_THRESHOLD   = 3'd3,
        CFG_SOFT_KNEE   = 3'd4,
        CFG_KNEE_A      = 3'd5,
        CFG_KNEE_B      = 3'd6,
        CFG_KNEE_C      = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SEL_PASS,
        SEL_RATIO_POS,
        SEL_RATIO_NEG,
        SEL_QUAD_POS,
        SEL_QUAD_NEG
    } t_comp_sel;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_comp_en;

    function automatic logic [THR_W-1:0] f_thr(input logic [THRESH_W-1:0] t);
        return (THR_W'(t) >> THR_SHR) << THR_SHL;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] f_sat(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acmc_comp.sv
`default_nettype none

module acmc_comp (
    input  wire logic                                      i_clk,
    input  wire acmc_pkg::t_comp_en                        i_en,
    input  wire logic signed [acmc_pkg::G_W-1:0]           i_g,
    input  wire logic        [acmc_pkg::RATIO_W-1:0]       i_ratio,
    input  wire logic        [acmc_pkg::THRESH_W-1:0]      i_thresh,
    input  wire logic                                      i_soft,
    input  wire logic signed [acmc_pkg::KNEE_W-1:0]        i_knee_a,
    input  wire logic signed [acmc_pkg::KNEE_W-1:0]        i_knee_b,
    input  wire logic signed [acmc_pkg::KNEE_W-1:0]        i_knee_c,
    output logic signed      [acmc_pkg::CL_W-1:0]          o_cl
);

    localparam int G_W        = acmc_pkg::G_W;
    localparam int D_W        = acmc_pkg::D_W;
    localparam int SC_W       = acmc_pkg::SC_W;
    localparam int R_W        = acmc_pkg::R_W;
    localparam int V_W        = acmc_pkg::V_W;
    localparam int AV_W       = acmc_pkg::AV_W;
    localparam int CT_W       = acmc_pkg::CT_W;
    localparam int CTS_W      = acmc_pkg::CTS_W;
    localparam int Q_W        = acmc_pkg::Q_W;
    localparam int RR_W       = acmc_pkg::RR_W;
    localparam int CL_W       = acmc_pkg::CL_W;
    localparam int RATIO_W    = acmc_pkg::RATIO_W;
    localparam int KNEE_W     = acmc_pkg::KNEE_W;
    localparam int FRAC_BITS  = acmc_pkg::FRAC_BITS;
    localparam int RATIO_FRAC = acmc_pkg::RATIO_FRAC;
    localparam int KNEE_FRAC  = acmc_pkg::KNEE_FRAC;
    localparam int SCP_W      = D_W + RATIO_W + 1;
    localparam int KP_W       = KNEE_W + V_W + 1;

    logic signed [D_W-1:0]     thr_d;
    logic signed [D_W-1:0]     base_d;
    logic signed [D_W-1:0]     g_d;
    acmc_pkg::t_comp_sel       n_sel;
    logic signed [D_W-1:0]     n_d;
    logic signed [SCP_W-1:0]   n_sc_p;
    logic signed [D_W-1:0]     n_vs;
    logic        [V_W-1:0]     n_v;
    logic        [2*V_W-1:0]   n_vv;
    logic signed [KP_W-1:0]    n_bv_p;

    acmc_pkg::t_comp_sel       r2_sel;
    logic signed [SC_W-1:0]    r2_sc;
    logic        [V_W-1:0]     r2_v2;
    logic signed [AV_W-1:0]    r2_bv;
    logic signed [D_W-1:0]     r2_base;
    logic signed [G_W-1:0]     r2_g;

    logic signed [KP_W-1:0]    n_av_p;
    logic signed [R_W-1:0]     n_hard;
    acmc_pkg::t_comp_sel       r3_sel;
    logic signed [AV_W-1:0]    r3_av;
    logic signed [AV_W-1:0]    r3_bv;
    logic signed [R_W-1:0]     r3_hard;
    logic signed [G_W-1:0]     r3_g;

    logic signed [CT_W-1:0]    ct_full;
    logic signed [CTS_W-1:0]   ct;
    logic signed [Q_W-1:0]     n_q;
    logic signed [RR_W-1:0]    n_r;
    logic signed [RR_W-1:0]    n_cl;
    logic signed [CL_W-1:0]    r4_cl;

    always_comb begin
        thr_d  = D_W'(acmc_pkg::f_thr(i_thresh));
        base_d = i_soft ? acmc_pkg::ONE_D : thr_d;
        g_d    = D_W'(i_g);
        if (i_ratio == acmc_pkg::UNITY_RATIO) begin
            n_sel = acmc_pkg::SEL_PASS;
        end else if (!i_soft) begin
            if (g_d > thr_d) begin
                n_sel = acmc_pkg::SEL_RATIO_POS;
            end else if (g_d < -thr_d) begin
                n_sel = acmc_pkg::SEL_RATIO_NEG;
            end else begin
                n_sel = acmc_pkg::SEL_PASS;
            end
        end else begin
            if (g_d > acmc_pkg::ONE_D) begin
                n_sel = acmc_pkg::SEL_RATIO_POS;
            end else if (g_d > thr_d) begin
                n_sel = acmc_pkg::SEL_QUAD_POS;
            end else if (g_d < -acmc_pkg::ONE_D) begin
                n_sel = acmc_pkg::SEL_RATIO_NEG;
            end else if (g_d < -thr_d) begin
                n_sel = acmc_pkg::SEL_QUAD_NEG;
            end else begin
                n_sel = acmc_pkg::SEL_PASS;
            end
        end
        n_d    = (n_sel == acmc_pkg::SEL_RATIO_NEG) ? g_d + base_d : g_d - base_d;
        n_sc_p = SCP_W'(n_d) * $signed({1'b0, i_ratio});
        n_vs   = (n_sel == acmc_pkg::SEL_QUAD_NEG) ? -g_d : g_d;
        n_v    = n_vs[V_W-1:0];
        n_vv   = (2*V_W)'(n_v) * (2*V_W)'(n_v);
        n_bv_p = KP_W'(i_knee_b) * $signed({1'b0, n_v});
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r2_sel  <= n_sel;
            r2_sc   <= n_sc_p[RATIO_FRAC +: SC_W];
            r2_v2   <= n_vv[FRAC_BITS +: V_W];
            r2_bv   <= n_bv_p[KNEE_FRAC +: AV_W];
            r2_base <= base_d;
            r2_g    <= i_g;
        end
    end

    always_comb begin
        n_av_p = KP_W'(i_knee_a) * $signed({1'b0, r2_v2});
        if (r2_sel == acmc_pkg::SEL_RATIO_NEG) begin
            n_hard = R_W'(r2_sc) - R_W'(r2_base);
        end else begin
            n_hard = R_W'(r2_sc) + R_W'(r2_base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r3_sel  <= r2_sel;
            r3_av   <= n_av_p[KNEE_FRAC +: AV_W];
            r3_bv   <= r2_bv;
            r3_hard <= n_hard;
            r3_g    <= r2_g;
        end
    end

    always_comb begin
        ct_full = CT_W'(i_knee_c) <<< FRAC_BITS;
        ct      = ct_full[KNEE_FRAC +: CTS_W];
        n_q     = Q_W'(r3_av) + Q_W'(r3_bv) + Q_W'(ct);
        case (r3_sel)
            acmc_pkg::SEL_PASS:      n_r = RR_W'(r3_g);
            acmc_pkg::SEL_RATIO_POS: n_r = RR_W'(r3_hard);
            acmc_pkg::SEL_RATIO_NEG: n_r = RR_W'(r3_hard);
            acmc_pkg::SEL_QUAD_POS:  n_r = RR_W'(n_q);
            acmc_pkg::SEL_QUAD_NEG:  n_r = -RR_W'(n_q);
            default:                 n_r = RR_W'(r3_g);
        endcase
        if (n_r > acmc_pkg::CL_HI) begin
            n_cl = acmc_pkg::CL_HI;
        end else if (n_r < acmc_pkg::CL_LO) begin
            n_cl = acmc_pkg::CL_LO;
        end else begin
            n_cl = n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r4_cl <= n_cl[CL_W-1:0];
        end
    end

    assign o_cl = r4_cl;

endmodule

`default_nettype wire

FILE: rtl/audio_compressor_mix_chain_unit.sv
`default_nettype none

// Channel   Handshake                     Payload
// input     i_in_valid / o_in_stall       i_left_sample, i_right_sample
// output    o_out_valid / i_out_stall     o_main_left, o_main_right, o_left_surround,
//                                         o_right_surround, o_low_freq
// config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One item enters per cycle while o_in_stall is low.
// The six stages are the input gain, the ratio and square products with the surround gain,
// the quadratic coefficient, the quadratic sum and clamp, the LFE gain, and the final mix
// with saturation, each followed by a register.
// Reset clears the valid bits and loads the register defaults.
// An output stall holds the last stage; earlier stages keep filling any empty slot.

module audio_compressor_mix_chain_unit (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_in_valid,
    output logic                                             o_in_stall,
    input  wire logic signed [acmc_pkg::SAMPLE_BITS-1:0]     i_left_sample,
    input  wire logic signed [acmc_pkg::SAMPLE_BITS-1:0]     i_right_sample,
    output logic                                             o_out_valid,
    input  wire logic                                        i_out_stall,
    output logic signed      [acmc_pkg::SAMPLE_BITS-1:0]     o_main_left,
    output logic signed      [acmc_pkg::SAMPLE_BITS-1:0]     o_main_right,
    output logic signed      [acmc_pkg::SAMPLE_BITS-1:0]     o_left_surround,
    output logic signed      [acmc_pkg::SAMPLE_BITS-1:0]     o_right_surround,
    output logic signed      [acmc_pkg::SAMPLE_BITS-1:0]     o_low_freq,
    input  wire logic                                        i_cfg_valid,
    output logic                                             o_cfg_ready,
    input  wire logic        [acmc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic        [acmc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int STAGES      = acmc_pkg::STAGES;
    localparam int SAMPLE_BITS = acmc_pkg::SAMPLE_BITS;
    localparam int G_W         = acmc_pkg::G_W;
    localparam int CL_W        = acmc_pkg::CL_W;
    localparam int GAIN_W      = acmc_pkg::GAIN_W;
    localparam int RATIO_W     = acmc_pkg::RATIO_W;
    localparam int THRESH_W    = acmc_pkg::THRESH_W;
    localparam int KNEE_W      = acmc_pkg::KNEE_W;
    localparam int MIXG_W      = acmc_pkg::MIXG_W;
    localparam int MIX_W       = acmc_pkg::MIX_W;
    localparam int SAT_W       = acmc_pkg::SAT_W;
    localparam int GAIN_FRAC   = acmc_pkg::GAIN_FRAC;
    localparam int MIX_FRAC    = acmc_pkg::MIX_FRAC;
    localparam int GP_W        = SAMPLE_BITS + GAIN_W + 1;
    localparam int MP_W        = G_W + MIXG_W;

    logic        [GAIN_W-1:0]      r_input_gain;
    logic                          r_mode_select;
    logic        [RATIO_W-1:0]     r_ratio;
    logic        [THRESH_W-1:0]    r_threshold;
    logic                          r_soft_knee;
    logic signed [KNEE_W-1:0]      r_knee_a;
    logic signed [KNEE_W-1:0]      r_knee_b;
    logic signed [KNEE_W-1:0]      r_knee_c;

    logic [STAGES-1:0]             r_vld;
    logic [STAGES-1:0]             stage_adv;
    acmc_pkg::t_comp_en            comp_en;

    logic signed [GP_W-1:0]        n_gl_p;
    logic signed [GP_W-1:0]        n_gr_p;
    logic signed [G_W-1:0]         r1_gl;
    logic signed [G_W-1:0]         r1_gr;

    logic signed [MIXG_W-1:0]      surr_gain;
    logic signed [MIXG_W-1:0]      lfe_gain;
    logic signed [MP_W-1:0]        n_ls_p;
    logic signed [G_W-1:0]         r2_gl;
    logic signed [G_W-1:0]         r2_gr;
    logic signed [MIX_W-1:0]       r2_ls;

    logic signed [SAT_W-1:0]       r3_lsg;
    logic signed [SAMPLE_BITS-1:0] r3_ls;
    logic signed [SAMPLE_BITS-1:0] r3_mr;
    logic signed [SAMPLE_BITS-1:0] r3_rs;

    logic signed [SAT_W-1:0]       r4_lsg;
    logic signed [SAMPLE_BITS-1:0] r4_ls;
    logic signed [SAMPLE_BITS-1:0] r4_mr;
    logic signed [SAMPLE_BITS-1:0] r4_rs;
    logic signed [CL_W-1:0]        w_cl;

    logic signed [MP_W-1:0]        n_lfe_p;
    logic signed [MIX_W-1:0]       r5_lfe;
    logic signed [SAT_W-1:0]       r5_lsg;
    logic signed [SAMPLE_BITS-1:0] r5_ls;
    logic signed [SAMPLE_BITS-1:0] r5_mr;
    logic signed [SAMPLE_BITS-1:0] r5_rs;

    logic signed [SAMPLE_BITS-1:0] r6_ml;
    logic signed [SAMPLE_BITS-1:0] r6_mr;
    logic signed [SAMPLE_BITS-1:0] r6_ls;
    logic signed [SAMPLE_BITS-1:0] r6_rs;
    logic signed [SAMPLE_BITS-1:0] r6_lfe;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_gain  <= GAIN_W'(32845);
            r_mode_select <= 1'b0;
            r_ratio       <= RATIO_W'(3277);
            r_threshold   <= THRESH_W'(2516582);
            r_soft_knee   <= 1'b0;
            r_knee_a      <= -KNEE_W'(11384540);
            r_knee_b      <= KNEE_W'(23607943);
            r_knee_c      <= -KNEE_W'(1024608);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (acmc_pkg::t_cfg_idx'(i_cfg_index))
                acmc_pkg::CFG_INPUT_GAIN:  r_input_gain  <= i_cfg_data[GAIN_W-1:0];
                acmc_pkg::CFG_MODE_SELECT: r_mode_select <= i_cfg_data[0];
                acmc_pkg::CFG_RATIO:       r_ratio       <= i_cfg_data[RATIO_W-1:0];
                acmc_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data[THRESH_W-1:0];
                acmc_pkg::CFG_SOFT_KNEE:   r_soft_knee   <= i_cfg_data[0];
                acmc_pkg::CFG_KNEE_A:      r_knee_a      <= i_cfg_data[KNEE_W-1:0];
                acmc_pkg::CFG_KNEE_B:      r_knee_b      <= i_cfg_data[KNEE_W-1:0];
                acmc_pkg::CFG_KNEE_C:      r_knee_c      <= i_cfg_data[KNEE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    always_comb begin
        stage_adv[STAGES-1] = !r_vld[STAGES-1] || !i_out_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            stage_adv[k] = !r_vld[k] || stage_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (stage_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !stage_adv[0];
    assign o_out_valid = r_vld[STAGES-1];

    always_comb begin
        n_gl_p = GP_W'(i_left_sample) * $signed({1'b0, r_input_gain});
        n_gr_p = GP_W'(i_right_sample) * $signed({1'b0, r_input_gain});
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[0]) begin
            r1_gl <= n_gl_p[GAIN_FRAC +: G_W];
            r1_gr <= n_gr_p[GAIN_FRAC +: G_W];
        end
    end

    always_comb begin
        surr_gain = r_mode_select ? acmc_pkg::GAIN_S1 : acmc_pkg::GAIN_S0;
        lfe_gain  = r_mode_select ? acmc_pkg::GAIN_L1 : acmc_pkg::GAIN_L0;
        n_ls_p    = MP_W'(r1_gl) * MP_W'(surr_gain);
        n_lfe_p   = MP_W'(w_cl) * MP_W'(lfe_gain);
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[1]) begin
            r2_gl <= r1_gl;
            r2_gr <= r1_gr;
            r2_ls <= n_ls_p[MIX_FRAC +: MIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[2]) begin
            r3_lsg <= SAT_W'(r2_ls) + SAT_W'(r2_gl);
            r3_ls  <= acmc_pkg::f_sat(SAT_W'(r2_ls));
            r3_mr  <= acmc_pkg::f_sat(SAT_W'(r2_gr));
            r3_rs  <= acmc_pkg::f_sat(-SAT_W'(r2_gr));
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[3]) begin
            r4_lsg <= r3_lsg;
            r4_ls  <= r3_ls;
            r4_mr  <= r3_mr;
            r4_rs  <= r3_rs;
        end
    end

    always_comb begin
        comp_en.s2 = stage_adv[1];
        comp_en.s3 = stage_adv[2];
        comp_en.s4 = stage_adv[3];
    end

    acmc_comp u_comp (
        .i_clk    (i_clk),
        .i_en     (comp_en),
        .i_g      (r1_gl),
        .i_ratio  (r_ratio),
        .i_thresh (r_threshold),
        .i_soft   (r_soft_knee),
        .i_knee_a (r_knee_a),
        .i_knee_b (r_knee_b),
        .i_knee_c (r_knee_c),
        .o_cl     (w_cl)
    );

    always_ff @(posedge i_clk) begin
        if (stage_adv[4]) begin
            r5_lfe <= n_lfe_p[MIX_FRAC +: MIX_W];
            r5_lsg <= r4_lsg;
            r5_ls  <= r4_ls;
            r5_mr  <= r4_mr;
            r5_rs  <= r4_rs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[5]) begin
            r6_ml  <= acmc_pkg::f_sat(r5_lsg + SAT_W'(r5_lfe));
            r6_lfe <= acmc_pkg::f_sat(SAT_W'(r5_lfe));
            r6_ls  <= r5_ls;
            r6_mr  <= r5_mr;
            r6_rs  <= r5_rs;
        end
    end

    assign o_main_left      = r6_ml;
    assign o_main_right     = r6_mr;
    assign o_left_surround  = r6_ls;
    assign o_right_surround = r6_rs;
    assign o_low_freq       = r6_lfe;

endmodule

`default_nettype wire
